>>> design/sensor_reciprocal_gain_estimate_macros.svh
// Assertion helpers used by the checker of this block.
`ifndef SENSOR_RECIPROCAL_GAIN_ESTIMATE_MACROS_SVH
`define SENSOR_RECIPROCAL_GAIN_ESTIMATE_MACROS_SVH

// Checked only outside reset.
`define SRGE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define SRGE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/srge_pkg.sv
package srge_pkg;

  localparam int WORD_W = 24;
  localparam int GAIN_W = 4;
  localparam int RECIP_W = 8;
  localparam int OFF_W = 12;
  localparam int SENS_W = 24;
  localparam int GAIN_BASE = 8;

  localparam int PG_LSB = 20;
  localparam int NG_LSB = 16;
  localparam int PR_LSB = 8;
  localparam int NR_LSB = 0;

  localparam int DIV1_PER = 4;
  localparam int DIV1_STAGES = SENS_W / DIV1_PER;
  localparam int DIV2_PER = 2;

  localparam int APB_DW = 32;
  localparam int ADDR_W = 3;

  localparam logic [OFF_W-1:0] P_OFFSET_RST = 12'd235;
  localparam logic [OFF_W-1:0] N_OFFSET_RST = 12'd385;

  localparam logic [0:0] REG_P_OFFSET = 1'b0;
  localparam logic [0:0] REG_N_OFFSET = 1'b1;

endpackage

>>> design/srge_in_if.sv
interface srge_in_if;
  logic                       valid;
  logic                       ready;
  logic [srge_pkg::WORD_W-1:0] prev_word;

  modport source (output valid, output prev_word, input ready);
  modport sink (input valid, input prev_word, output ready);
endinterface

>>> design/srge_out_if.sv
interface srge_out_if;
  logic                       valid;
  logic                       ready;
  logic [srge_pkg::WORD_W-1:0] new_word;
  logic                       divide_error;

  modport source (output valid, output new_word, output divide_error, input ready);
  modport sink (input valid, input new_word, input divide_error, output ready);
endinterface

>>> design/sensor_reciprocal_gain_estimate.sv
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    prev_word[23:0]
// out_ch    out  valid/ready    new_word[23:0], divide_error
// apb       in   psel/penable   paddr[2:0], pwdata[31:0], prdata[31:0]
//
// One item per cycle while out_ch is not stalled; 11 + ceil(log2(RECIP_LIMIT)/2) register stages (15 at defaults).
// The rebuild divider takes four quotient bits per stage, the gain divider two.
// rst_n (sync) empties the pipeline and restores the offsets; payload is not reset.
// A stall on out_ch freezes every stage at once; in_ch.ready drops with it.
module sensor_reciprocal_gain_estimate #(
  parameter int GAIN_LIMIT  = 16,
  parameter int RECIP_LIMIT = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  srge_in_if.sink                       in_ch,
  srge_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srge_pkg::ADDR_W-1:0]   paddr,
  input  logic [srge_pkg::APB_DW-1:0]   pwdata,
  output logic [srge_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int SENS_W  = srge_pkg::SENS_W;
  localparam int GAIN_W  = srge_pkg::GAIN_W;
  localparam int RECIP_W = srge_pkg::RECIP_W;
  localparam int WORD_W  = srge_pkg::WORD_W;
  localparam int QW      = $clog2(RECIP_LIMIT);
  localparam int RLW     = $clog2(RECIP_LIMIT + 1);
  localparam int PW      = SENS_W + RLW;
  localparam int D2W     = SENS_W + QW;
  localparam int D2S     = (QW + srge_pkg::DIV2_PER - 1) / srge_pkg::DIV2_PER;
  localparam int ST_ADD  = srge_pkg::DIV1_STAGES + 1;
  localparam int ST_MUL  = ST_ADD + 1;
  localparam int ST_SRCH = ST_MUL + 1;
  localparam int ST_D2   = ST_SRCH + 1;
  localparam int ST_PACK = ST_D2 + D2S;
  localparam int NS      = ST_PACK + 1;

  localparam logic [RECIP_W-1:0] RECIP_SAT = RECIP_W'(RECIP_LIMIT - 1);

  typedef struct packed {
    logic [GAIN_W-1:0]  g;
    logic [RECIP_W-1:0] r;
    logic [SENS_W-1:0]  dvd;
    logic [RECIP_W-1:0] rem;
    logic [SENS_W-1:0]  val;
    logic [PW-1:0]      prod;
    logic               sat;
    logic [GAIN_W-1:0]  ng;
    logic [SENS_W-1:0]  rem2;
    logic [D2W-1:0]     d2;
    logic [QW-1:0]      q2;
  } half_t;

  typedef struct packed {
    logic              err;
    logic [WORD_W-1:0] word;
    half_t             p;
    half_t             n;
  } item_t;

  logic [srge_pkg::OFF_W-1:0] p_off_r;
  logic [srge_pkg::OFF_W-1:0] n_off_r;
  logic [NS-1:0]              v_r;
  item_t                      st_r [NS];
  logic                       en;

  function automatic half_t start_half(logic [GAIN_W-1:0] g, logic [RECIP_W-1:0] r);
    half_t h;
    h = '0;
    h.g = g;
    h.r = r;
    h.dvd = SENS_W'(1) << ({1'b0, g} + 5'(srge_pkg::GAIN_BASE));
    return h;
  endfunction

  function automatic item_t decode(logic [WORD_W-1:0] w);
    item_t it;
    it = '0;
    it.err = (w[srge_pkg::PR_LSB +: RECIP_W] == '0) || (w[srge_pkg::NR_LSB +: RECIP_W] == '0);
    it.p = start_half(w[srge_pkg::PG_LSB +: GAIN_W], w[srge_pkg::PR_LSB +: RECIP_W]);
    it.n = start_half(w[srge_pkg::NG_LSB +: GAIN_W], w[srge_pkg::NR_LSB +: RECIP_W]);
    return it;
  endfunction

  // one restoring step of 2^(g+8) / r, dividend bits shifted in from the top
  function automatic half_t div1_step(half_t h);
    logic [RECIP_W:0] rem9;
    logic             take;
    rem9 = {h.rem, h.dvd[SENS_W-1]};
    take = rem9 >= {1'b0, h.r};
    h.dvd = {h.dvd[SENS_W-2:0], 1'b0};
    h.rem = take ? RECIP_W'(rem9 - {1'b0, h.r}) : rem9[RECIP_W-1:0];
    h.val = {h.val[SENS_W-2:0], take};
    return h;
  endfunction

  function automatic half_t search(half_t h);
    logic [GAIN_W-1:0] best;
    logic              found;
    best = '0;
    found = 1'b0;
    for (int g = 0; g < GAIN_LIMIT; g++) begin
      if (h.prod > (PW'(1) << (g + srge_pkg::GAIN_BASE))) begin
        best = GAIN_W'(g);
        found = 1'b1;
      end
    end
    h.sat = !found;
    h.ng = best;
    h.rem2 = SENS_W'(1) << ({1'b0, best} + 5'(srge_pkg::GAIN_BASE));
    h.d2 = D2W'(h.val) << (QW - 1);
    h.q2 = '0;
    return h;
  endfunction

  function automatic half_t div2_step(half_t h);
    logic ge;
    ge = D2W'(h.rem2) >= h.d2;
    h.rem2 = ge ? SENS_W'(D2W'(h.rem2) - h.d2) : h.rem2;
    h.q2 = (h.q2 << 1) | QW'(ge);
    h.d2 = h.d2 >> 1;
    return h;
  endfunction

  function automatic logic [RECIP_W-1:0] recip_of(half_t h);
    return h.sat ? RECIP_SAT : RECIP_W'(h.q2);
  endfunction

  assign en = !v_r[NS-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], in_ch.valid};
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    item_t st_nxt;

    if (k == 0) begin : g_in
      always_comb begin
        st_nxt = decode(in_ch.prev_word);
      end
    end else if (k < ST_ADD) begin : g_div1
      always_comb begin
        st_nxt = st_r[k-1];
        for (int j = 0; j < srge_pkg::DIV1_PER; j++) begin
          st_nxt.p = div1_step(st_nxt.p);
          st_nxt.n = div1_step(st_nxt.n);
        end
      end
    end else if (k == ST_ADD) begin : g_add
      always_comb begin
        st_nxt = st_r[k-1];
        st_nxt.p.val = st_r[k-1].p.val + SENS_W'(p_off_r);
        st_nxt.n.val = st_r[k-1].n.val + SENS_W'(n_off_r);
      end
    end else if (k == ST_MUL) begin : g_mul
      always_comb begin
        st_nxt = st_r[k-1];
        st_nxt.p.prod = PW'(st_r[k-1].p.val) * PW'(RECIP_LIMIT);
        st_nxt.n.prod = PW'(st_r[k-1].n.val) * PW'(RECIP_LIMIT);
      end
    end else if (k == ST_SRCH) begin : g_srch
      always_comb begin
        st_nxt = st_r[k-1];
        st_nxt.p = search(st_r[k-1].p);
        st_nxt.n = search(st_r[k-1].n);
      end
    end else if (k < ST_PACK) begin : g_div2
      always_comb begin
        st_nxt = st_r[k-1];
        for (int j = 0; j < srge_pkg::DIV2_PER; j++) begin
          if ((k - ST_D2) * srge_pkg::DIV2_PER + j < QW) begin
            st_nxt.p = div2_step(st_nxt.p);
            st_nxt.n = div2_step(st_nxt.n);
          end
        end
      end
    end else begin : g_pack
      always_comb begin
        st_nxt = st_r[k-1];
        st_nxt.word = '0;
        if (!st_r[k-1].err) begin
          st_nxt.word[srge_pkg::PG_LSB +: GAIN_W] = st_r[k-1].p.ng;
          st_nxt.word[srge_pkg::NG_LSB +: GAIN_W] = st_r[k-1].n.ng;
          st_nxt.word[srge_pkg::PR_LSB +: RECIP_W] = recip_of(st_r[k-1].p);
          st_nxt.word[srge_pkg::NR_LSB +: RECIP_W] = recip_of(st_r[k-1].n);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= st_nxt;
      end
    end
  end

  assign out_ch.valid        = v_r[NS-1];
  assign out_ch.new_word     = st_r[NS-1].word;
  assign out_ch.divide_error = st_r[NS-1].err;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_off_r <= srge_pkg::P_OFFSET_RST;
      n_off_r <= srge_pkg::N_OFFSET_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[srge_pkg::ADDR_W-1:2])
        srge_pkg::REG_P_OFFSET: p_off_r <= pwdata[srge_pkg::OFF_W-1:0];
        srge_pkg::REG_N_OFFSET: n_off_r <= pwdata[srge_pkg::OFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[srge_pkg::ADDR_W-1:2])
      srge_pkg::REG_P_OFFSET: prdata = srge_pkg::APB_DW'(p_off_r);
      srge_pkg::REG_N_OFFSET: prdata = srge_pkg::APB_DW'(n_off_r);
      default:                prdata = '0;
    endcase
  end

  assign pready = 1'b1;

endmodule

>>> design/srge_checker.sv
`include "sensor_reciprocal_gain_estimate_macros.svh"

module srge_checker #(
  parameter int GAIN_LIMIT  = 16,
  parameter int RECIP_LIMIT = 256
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [srge_pkg::WORD_W-1:0] new_word,
  input logic                        divide_error
);

  `SRGE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(new_word) && $stable(divide_error), "out item changed while stalled")
  `SRGE_ASSERT(a_err_zero, out_valid && divide_error |-> new_word == '0, "divide error with nonzero word")
  `SRGE_ASSERT(a_limits, out_valid |-> (new_word[23:20] <= GAIN_LIMIT - 1) && (new_word[19:16] <= GAIN_LIMIT - 1) && (new_word[15:8] <= RECIP_LIMIT - 1) && (new_word[7:0] <= RECIP_LIMIT - 1), "field beyond its limit")
  `SRGE_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "item out after reset")

endmodule

bind sensor_reciprocal_gain_estimate srge_checker #(
  .GAIN_LIMIT  (GAIN_LIMIT),
  .RECIP_LIMIT (RECIP_LIMIT)
) u_srge_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .new_word     (out_ch.new_word),
  .divide_error (out_ch.divide_error)
);

>>> tb/sensor_reciprocal_gain_estimate_tb.sv
module sensor_reciprocal_gain_estimate_tb;
  import srge_pkg::*;

  localparam int GAIN_LIMIT  = 16;
  localparam int RECIP_LIMIT = 256;
  localparam int PIPE_DRAIN  = 24;
  localparam int HOLD_CYCLES = 90;

  localparam logic [ADDR_W-1:0] ADDR_P_OFFSET = {REG_P_OFFSET, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_N_OFFSET = {REG_N_OFFSET, 2'b00};

  typedef struct packed {
    logic [WORD_W-1:0] new_word;
    logic              divide_error;
  } gain_result_t;

  class gain_scoreboard;
    logic [OFF_W-1:0] p_off;
    logic [OFF_W-1:0] n_off;
    gain_result_t     expected_q[$];
    int               errors;

    function new();
      p_off  = P_OFFSET_RST;
      n_off  = N_OFFSET_RST;
      errors = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function logic [31:0] rebuild(logic [GAIN_W-1:0] g, logic [RECIP_W-1:0] r,
                                  logic [OFF_W-1:0] off);
      logic [31:0] pow2;
      pow2 = 32'd1 << (32'(g) + GAIN_BASE);
      return pow2 / 32'(r) + 32'(off);
    endfunction

    // {gain, recip} of the largest gain whose quotient stays under the limit
    function logic [GAIN_W+RECIP_W-1:0] best_setting(logic [31:0] sensor);
      logic [31:0]        q;
      logic [GAIN_W-1:0]  g_best;
      logic [RECIP_W-1:0] r_best;
      g_best = '0;
      r_best = RECIP_W'(RECIP_LIMIT - 1);
      for (int g = 0; g < GAIN_LIMIT; g++) begin
        q = (32'd1 << (g + GAIN_BASE)) / sensor;
        if (q < RECIP_LIMIT) begin
          g_best = GAIN_W'(g);
          r_best = q[RECIP_W-1:0];
        end
      end
      return {g_best, r_best};
    endfunction

    function gain_result_t predict(logic [WORD_W-1:0] w);
      gain_result_t               res;
      logic [GAIN_W+RECIP_W-1:0]  ps;
      logic [GAIN_W+RECIP_W-1:0]  ns;
      logic [RECIP_W-1:0]         pr;
      logic [RECIP_W-1:0]         nr;
      pr = w[PR_LSB +: RECIP_W];
      nr = w[NR_LSB +: RECIP_W];
      if (pr == '0 || nr == '0) begin
        res.new_word     = '0;
        res.divide_error = 1'b1;
      end else begin
        ps = best_setting(rebuild(w[PG_LSB +: GAIN_W], pr, p_off));
        ns = best_setting(rebuild(w[NG_LSB +: GAIN_W], nr, n_off));
        res.new_word = '0;
        res.new_word[PG_LSB +: GAIN_W]  = ps[RECIP_W +: GAIN_W];
        res.new_word[NG_LSB +: GAIN_W]  = ns[RECIP_W +: GAIN_W];
        res.new_word[PR_LSB +: RECIP_W] = ps[RECIP_W-1:0];
        res.new_word[NR_LSB +: RECIP_W] = ns[RECIP_W-1:0];
        res.divide_error = 1'b0;
      end
      return res;
    endfunction

    function void note(logic [WORD_W-1:0] w);
      expected_q.push_back(predict(w));
    endfunction

    task check(logic [WORD_W-1:0] word, logic err);
      gain_result_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected item new_word=%h divide_error=%b", word, err));
        return;
      end
      e = expected_q.pop_front();
      if (word !== e.new_word)
        report($sformatf("new_word %h, wanted %h", word, e.new_word));
      if (err !== e.divide_error)
        report($sformatf("divide_error %b, wanted %b", err, e.divide_error));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  srge_in_if  in_bus ();
  srge_out_if out_bus ();

  sensor_reciprocal_gain_estimate #(
    .GAIN_LIMIT (GAIN_LIMIT),
    .RECIP_LIMIT(RECIP_LIMIT)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  gain_scoreboard sb = new();

  int send_pct;
  int recv_pct;
  int hold_req;
  int hold_seen;
  int hold_cnt;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // long receiver stall, counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_seen <= 0;
      hold_cnt  <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt  <= HOLD_CYCLES;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready)
      sb.check(out_bus.new_word, out_bus.divide_error);
  end

  task automatic send_item(logic [WORD_W-1:0] w);
    while ($urandom_range(99) < send_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.prev_word <= w;
    do @(posedge clk); while (!in_bus.ready);
    sb.note(w);
  endtask

  task automatic end_burst();
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic apb_read(logic [ADDR_W-1:0] addr, output logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [APB_DW-1:0] data);
    logic [APB_DW-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_P_OFFSET) sb.p_off = data[OFF_W-1:0];
    else sb.n_off = data[OFF_W-1:0];
    @(posedge clk);
    apb_read(addr, rd);
    if (rd !== APB_DW'(data[OFF_W-1:0]))
      sb.report($sformatf("readback %h at %h, wanted %h", rd, addr, data[OFF_W-1:0]));
  endtask

  task automatic check_offsets();
    logic [APB_DW-1:0] rd;
    apb_read(ADDR_P_OFFSET, rd);
    if (rd !== APB_DW'(sb.p_off))
      sb.report($sformatf("p_offset reads %h, wanted %h", rd, sb.p_off));
    apb_read(ADDR_N_OFFSET, rd);
    if (rd !== APB_DW'(sb.n_off))
      sb.report($sformatf("n_offset reads %h, wanted %h", rd, sb.n_off));
  endtask

  function automatic logic [WORD_W-1:0] random_word();
    logic [WORD_W-1:0] w;
    int                pick;
    w    = WORD_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 8) begin
      // broken item: a zero reciprocal on one or both halves
      if ($urandom_range(1)) w[PR_LSB +: RECIP_W] = '0;
      if ($urandom_range(1) || w[PR_LSB +: RECIP_W] != '0) w[NR_LSB +: RECIP_W] = '0;
    end else begin
      if (pick < 30) begin
        // tiny sensor values, towards saturation
        w[PG_LSB +: GAIN_W]  = GAIN_W'($urandom_range(2));
        w[NG_LSB +: GAIN_W]  = GAIN_W'($urandom_range(2));
        w[PR_LSB +: RECIP_W] = RECIP_W'($urandom_range(255, 128));
        w[NR_LSB +: RECIP_W] = RECIP_W'($urandom_range(255, 128));
      end
      if (w[PR_LSB +: RECIP_W] == '0) w[PR_LSB +: RECIP_W] = RECIP_W'($urandom_range(255, 1));
      if (w[NR_LSB +: RECIP_W] == '0) w[NR_LSB +: RECIP_W] = RECIP_W'($urandom_range(255, 1));
    end
    return w;
  endfunction

  task automatic random_burst(int n, bit pressure);
    for (int i = 0; i < n; i++) begin
      if (pressure && i == 10) hold_req <= hold_req + 1;
      send_item(random_word());
    end
    end_burst();
  endtask

  task automatic extremes_burst();
    send_item(24'hFF0101);
    send_item(24'h00FFFF);
    send_item(24'hFFFFFF);
    send_item(24'h000000);
  endtask

  logic [WORD_W-1:0] directed_q[$] = '{
    24'h0000FF, 24'h00FF00, 24'hFF00FF, 24'hFFFF00, 24'h000101, 24'h0F80FF,
    24'hF0FF80, 24'hFF01FF, 24'hFFFF01, 24'h77A05C, 24'h880201, 24'h3355AA,
    24'hCC807F
  };

  initial begin
    rst_n            <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_bus.valid     <= 1'b0;
    in_bus.prev_word <= '0;
    hold_req         <= 0;
    send_pct = 35;
    recv_pct = 58;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    check_offsets();
    random_burst(110, 1'b0);

    apb_write(ADDR_P_OFFSET, 32'h0000_0000);
    apb_write(ADDR_N_OFFSET, 32'h0000_0000);
    extremes_burst();
    foreach (directed_q[i]) send_item(directed_q[i]);
    random_burst(100, 1'b0);

    send_pct = 58;
    recv_pct = 35;
    apb_write(ADDR_P_OFFSET, 32'hFFFF_FFFF);
    apb_write(ADDR_N_OFFSET, 32'hFFFF_FFFF);
    extremes_burst();
    random_burst(110, 1'b1);

    apb_write(ADDR_P_OFFSET, $urandom);
    apb_write(ADDR_N_OFFSET, $urandom);
    random_burst(110, 1'b0);

    send_pct = 0;
    recv_pct = 0;
    apb_write(ADDR_P_OFFSET, $urandom);
    apb_write(ADDR_N_OFFSET, $urandom);
    random_burst(130, 1'b1);

    apb_write(ADDR_P_OFFSET, 32'hABCD_E001);
    apb_write(ADDR_N_OFFSET, 32'h1234_5FFE);
    random_burst(130, 1'b0);

    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_DRAIN * 2) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/srge_pkg.sv
design/srge_in_if.sv
design/srge_out_if.sv
design/sensor_reciprocal_gain_estimate.sv
design/srge_checker.sv
tb/sensor_reciprocal_gain_estimate_tb.sv
